### rtl/core/ffd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffd_pkg: shared types and constants of the fixed frame deframer
// Frame layout constants and the decoded frame record.
// ----------------------------------------------------------------------------
package ffd_pkg;

   localparam int unsigned FRAME_LEN = 12;
   localparam int unsigned HIST_LEN  = FRAME_LEN - 1;
   localparam int unsigned CNT_W     = $clog2(FRAME_LEN);

   localparam logic [7:0] FRAME_HEAD = 8'h5A;
   localparam logic [7:0] FRAME_CR   = 8'h0D;
   localparam logic [7:0] FRAME_LF   = 8'h0A;

   // Byte offsets inside a frame.
   localparam int unsigned OFS_DEVICE = 1;
   localparam int unsigned OFS_ONBED  = 2;
   localparam int unsigned OFS_MOVE   = 3;
   localparam int unsigned OFS_BREATH = 4;
   localparam int unsigned OFS_HEART  = 5;
   localparam int unsigned OFS_TS     = 6;
   localparam int unsigned OFS_CR     = 10;

   typedef logic [7:0] byte_type;

   typedef struct packed {
      logic [7:0]  unit_id;
      logic [7:0]  on_bed;
      logic [7:0]  motion_flag;
      logic [7:0]  breaths;
      logic [7:0]  pulse;
      logic [31:0] timestamp;
   } frame_type;

endpackage : ffd_pkg
`default_nettype wire

### rtl/core/ffd_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffd_check: frame check and field extraction
// Looks at the eleven held bytes plus the incoming word as one candidate
// frame, flags header and trailer match and slices out the payload fields.
// ----------------------------------------------------------------------------
module ffd_check
   import ffd_pkg::*;
(
   input  wire byte_type  hist [HIST_LEN],
   input  wire byte_type  last_byte,
   output logic           good,
   output frame_type      fields
);

   always_comb begin
      good = (hist[0] == FRAME_HEAD) && (hist[OFS_CR] == FRAME_CR) &&
             (last_byte == FRAME_LF);
      fields.unit_id     = hist[OFS_DEVICE];
      fields.on_bed      = hist[OFS_ONBED];
      fields.motion_flag = hist[OFS_MOVE];
      fields.breaths     = hist[OFS_BREATH];
      fields.pulse       = hist[OFS_HEART];
      fields.timestamp   = {hist[OFS_TS], hist[OFS_TS + 1], hist[OFS_TS + 2],
                            hist[OFS_TS + 3]};
   end

endmodule : ffd_check
`default_nettype wire

### rtl/core/fixed_frame_deframer.sv
`default_nettype none
// A result word appears in the cycle after the word that completes a good frame.
// Throughput: one input word per cycle; the input stalls only while a result
// word is held and the result side is not ready.
// Reset: synchronous, active high; clears the held count and the result valid.
// History bytes are not cleared; they are only read once the count shows them written.
// ----------------------------------------------------------------------------
// fixed_frame_deframer: 12-byte frame hunter
// Keeps the last eleven bytes in a shift line and checks each new word
// against them; a good frame emits one result word and restarts the count.
// ----------------------------------------------------------------------------
module fixed_frame_deframer
   import ffd_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [7:0]  rsp_unit_id,
   output logic [7:0]  rsp_on_bed,
   output logic [7:0]  rsp_motion_flag,
   output logic [7:0]  rsp_breaths,
   output logic [7:0]  rsp_pulse,
   output logic [31:0] rsp_timestamp
);

   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(HIST_LEN);

   byte_type         hist_ff [HIST_LEN];
   logic [CNT_W-1:0] held_ff;
   logic             rsp_valid_ff;
   frame_type        rsp_ff;

   logic      accept;
   logic      good;
   frame_type fields;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   ffd_check u_check (
      .hist      (hist_ff),
      .last_byte (req_data_byte),
      .good      (good),
      .fields    (fields)
   );

   // History shift line; oldest byte at index zero.
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < HIST_LEN - 1; i++) begin
            hist_ff[i] <= hist_ff[i + 1];
         end
         hist_ff[HIST_LEN - 1] <= req_data_byte;
      end
   end

   // Count saturates at eleven: a bad frame drops its oldest byte and stays full.
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            if (held_ff != CNT_FULL) begin
               held_ff <= held_ff + 1'b1;
            end else if (good) begin
               held_ff <= '0;
            end
         end
         if (accept && held_ff == CNT_FULL && good) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && held_ff == CNT_FULL && good) begin
         rsp_ff <= fields;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_unit_id     = rsp_ff.unit_id;
   assign rsp_on_bed      = rsp_ff.on_bed;
   assign rsp_motion_flag = rsp_ff.motion_flag;
   assign rsp_breaths     = rsp_ff.breaths;
   assign rsp_pulse       = rsp_ff.pulse;
   assign rsp_timestamp   = rsp_ff.timestamp;

endmodule : fixed_frame_deframer
`default_nettype wire

### rtl/core/ffd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffd_checker: port-level checks for the fixed frame deframer
// Watches the top-level ports only and is bound to the top level.
// ----------------------------------------------------------------------------
module ffd_checker
   import ffd_pkg::*;
(
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_ready,
   input wire [7:0]  req_data_byte,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [31:0] rsp_timestamp
);

   // Nothing is pending right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A held result word keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_timestamp))
      else $error("stalled result word changed");

   // A waiting result word blocks the input side.
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while result stalled");

   // A new result follows an accepted word that closes the frame with LF.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_data_byte == FRAME_LF))
      else $error("result without a closing LF word");

endmodule : ffd_checker

bind fixed_frame_deframer ffd_checker u_ffd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_data_byte (req_data_byte),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_timestamp (rsp_timestamp)
);
`default_nettype wire

### dv/tb_fixed_frame_deframer.sv
// ----------------------------------------------------------------------------
// tb_fixed_frame_deframer: self-checking bench for the 12-byte frame hunter
// Streams directed and random bytes into the deframer, predicts every good
// frame with an independent sliding-window model, and compares each result
// word with the oldest predicted frame, with random idling on both sides in all but the last phase.
// ----------------------------------------------------------------------------
module tb_fixed_frame_deframer;
   import ffd_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_unit_id;
   logic [7:0]  rsp_on_bed;
   logic [7:0]  rsp_motion_flag;
   logic [7:0]  rsp_breaths;
   logic [7:0]  rsp_pulse;
   logic [31:0] rsp_timestamp;

   fixed_frame_deframer dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_unit_id     (rsp_unit_id),
      .rsp_on_bed      (rsp_on_bed),
      .rsp_motion_flag (rsp_motion_flag),
      .rsp_breaths     (rsp_breaths),
      .rsp_pulse       (rsp_pulse),
      .rsp_timestamp   (rsp_timestamp)
   );

   byte_type    stream_q[$];
   frame_type   frame_expq[$];
   byte_type    hunt_win[FRAME_LEN];
   int unsigned hunt_held;
   int unsigned bytes_pushed;
   int unsigned bytes_taken;
   int unsigned mismatches;
   int unsigned send_idle_pct;
   int unsigned rsp_idle_pct;
   logic        req_fire;
   logic        hold_on;

   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data_byte = '0;
      rsp_ready     = 1'b0;
      hold_on       = 1'b0;
      req_fire      = 1'b0;
      hunt_held     = 0;
      bytes_pushed  = 0;
      bytes_taken   = 0;
      mismatches    = 0;
      send_idle_pct = 13;
      rsp_idle_pct  = 66;
   end

   always #5 clock = ~clock;

   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;
   end

   // Sliding-window frame hunt: one call per accepted word.
   task automatic deframe_byte(input byte_type b);
      frame_type f;
      if (hunt_held >= FRAME_LEN) hunt_held = 0;
      hunt_win[hunt_held] = b;
      hunt_held++;
      if (hunt_held == FRAME_LEN) begin
         if (hunt_win[0] != FRAME_HEAD || hunt_win[OFS_CR] != FRAME_CR ||
             hunt_win[OFS_CR + 1] != FRAME_LF) begin
            for (int i = 0; i < HIST_LEN; i++) hunt_win[i] = hunt_win[i + 1];
            hunt_held = HIST_LEN;
         end else begin
            f.unit_id     = hunt_win[OFS_DEVICE];
            f.on_bed      = hunt_win[OFS_ONBED];
            f.motion_flag = hunt_win[OFS_MOVE];
            f.breaths     = hunt_win[OFS_BREATH];
            f.pulse       = hunt_win[OFS_HEART];
            f.timestamp   = {hunt_win[OFS_TS], hunt_win[OFS_TS + 1],
                             hunt_win[OFS_TS + 2], hunt_win[OFS_TS + 3]};
            frame_expq.push_back(f);
            hunt_held = 0;
         end
      end
   endtask

   task automatic push_byte(input byte_type b);
      stream_q.push_back(b);
      bytes_pushed++;
   endtask

   // Pushes the first keep bytes of a frame built from the given parts.
   task automatic push_frame(input byte_type body[9], input byte_type hd,
                             input byte_type cr, input byte_type lf,
                             input int unsigned keep);
      byte_type fr[FRAME_LEN];
      fr[0] = hd;
      for (int i = 0; i < 9; i++) fr[i + 1] = body[i];
      fr[OFS_CR]     = cr;
      fr[OFS_CR + 1] = lf;
      for (int i = 0; i < keep; i++) push_byte(fr[i]);
   endtask

   function automatic byte_type payload_byte();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 10) return 8'h00;
      if (r < 20) return 8'hFF;
      if (r < 24) return FRAME_HEAD;
      if (r < 27) return FRAME_CR;
      if (r < 30) return FRAME_LF;
      return byte_type'($urandom_range(255));
   endfunction

   function automatic byte_type other_than(input byte_type v);
      byte_type b;
      b = byte_type'($urandom_range(255));
      while (b == v) b = byte_type'($urandom_range(255));
      return b;
   endfunction

   // Mostly well-formed frames with random content; the rest are frames with
   // a broken header or trailer, cut-off frames and loose noise bytes.
   task automatic push_stream(input int unsigned n);
      byte_type    body[9];
      int unsigned start;
      int unsigned r;
      start = bytes_pushed;
      while (bytes_pushed - start < n) begin
         for (int i = 0; i < 9; i++) body[i] = payload_byte();
         r = $urandom_range(99);
         if (r < 65) begin
            push_frame(body, FRAME_HEAD, FRAME_CR, FRAME_LF, FRAME_LEN);
         end else if (r < 72) begin
            push_frame(body, other_than(FRAME_HEAD), FRAME_CR, FRAME_LF, FRAME_LEN);
         end else if (r < 79) begin
            push_frame(body, FRAME_HEAD, other_than(FRAME_CR), FRAME_LF, FRAME_LEN);
         end else if (r < 86) begin
            push_frame(body, FRAME_HEAD, FRAME_CR, other_than(FRAME_LF), FRAME_LEN);
         end else if (r < 93) begin
            push_frame(body, FRAME_HEAD, FRAME_CR, FRAME_LF, $urandom_range(1, HIST_LEN));
         end else begin
            repeat ($urandom_range(1, 5)) push_byte(byte_type'($urandom_range(255)));
         end
      end
   endtask

   // Stimulus and end of run.
   initial begin
      byte_type body[9];
      wait (!reset);
      // Two junk bytes ahead of a good frame force two slides before sync.
      push_byte(8'h00);
      push_byte(8'hFF);
      body = '{default: 8'hFF};
      push_frame(body, FRAME_HEAD, FRAME_CR, FRAME_LF, FRAME_LEN);
      // Correct header and CR with a wrong LF must not give a result.
      body = '{default: 8'h00};
      push_frame(body, FRAME_HEAD, FRAME_CR, 8'h0B, FRAME_LEN);
      push_stream(210);
      wait (bytes_taken == bytes_pushed);
      @(posedge clock);
      send_idle_pct = 66;
      rsp_idle_pct  = 13;
      push_stream(240);
      wait (bytes_taken == bytes_pushed);
      @(posedge clock);
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      push_stream(250);
      wait (bytes_taken == bytes_pushed);
      wait (frame_expq.size() == 0);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && frame_expq.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Long receiver hold-off in the last phase so the result register backs up
   // and the input side has to stall.
   initial begin
      wait (!reset);
      wait (bytes_taken >= 560);
      @(posedge clock);
      hold_on = 1'b1;
      repeat (300) @(posedge clock);
      hold_on = 1'b0;
   end

   initial begin
      #3000000;
      $display("end of test: mismatches");
      $finish;
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (stream_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid     <= 1'b1;
            req_data_byte <= stream_q.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !hold_on && ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      frame_type got;
      frame_type want;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            deframe_byte(req_data_byte);
            bytes_taken <= bytes_taken + 1;
         end
         if (rsp_valid && rsp_ready) begin
            got = {rsp_unit_id, rsp_on_bed, rsp_motion_flag, rsp_breaths,
                   rsp_pulse, rsp_timestamp};
            if (frame_expq.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result word: dev=%h bed=%h move=%h br=%h hr=%h ts=%h",
                           got.unit_id, got.on_bed, got.motion_flag, got.breaths,
                           got.pulse, got.timestamp);
            end else begin
               want = frame_expq.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("result word mismatch at %0t", $realtime);
                     $display("  expected dev=%h bed=%h move=%h br=%h hr=%h ts=%h",
                              want.unit_id, want.on_bed, want.motion_flag,
                              want.breaths, want.pulse, want.timestamp);
                     $display("  actual   dev=%h bed=%h move=%h br=%h hr=%h ts=%h",
                              got.unit_id, got.on_bed, got.motion_flag,
                              got.breaths, got.pulse, got.timestamp);
                  end
               end
            end
         end
      end
   end

endmodule

### files.f
rtl/core/ffd_pkg.sv
rtl/core/ffd_check.sv
rtl/core/fixed_frame_deframer.sv
rtl/core/ffd_checker.sv
dv/tb_fixed_frame_deframer.sv
